// ===== sv/msa_pkg.sv =====
package msa_pkg;

  // Field widths
  localparam int unsigned RATING_W = 8;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned SIM_W    = 29;
  localparam int unsigned NUM_W    = 29;
  localparam int unsigned MINC_W   = 7;
  localparam int unsigned PEN_W    = 16;
  localparam int unsigned SQ_W     = 2 * RATING_W;
  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SUM_W-1:0]  SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [MINC_W-1:0] MIN_COMMON_RST  = 7'd5;
  localparam logic [PEN_W-1:0]  PENALTY_RST     = 16'd1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_COMMON      = 8'd0,
    CFG_MISSING_PENALTY = 8'd1
  } msa_cfg_idx_e;

  // Configuration as seen by the back end
  typedef struct packed {
    logic [MINC_W-1:0] min_common;
    logic [PEN_W-1:0]  missing_penalty;
  } msa_cfg_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_DONE
  } msa_back_state_e;

endpackage

// ===== sv/msa_front.sv =====
module msa_front #(
  parameter int unsigned MAX_ITEMS = 4096,
  parameter int unsigned CNT_W     = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  logic [msa_pkg::RATING_W-1:0]        item_first_i,
  input  logic [msa_pkg::RATING_W-1:0]        item_second_i,
  input  logic                                item_last_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic [msa_pkg::SUM_W-1:0]           job_sum_o,
  output logic [CNT_W-1:0]                    job_cnt_o
);
  import msa_pkg::*;

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RATING_W-1:0] diff;
  logic [SQ_W-1:0]     sq;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic                hit;
  logic                accept;

  // Squared difference and saturating sum
  always_comb begin
    diff    = (item_first_i >= item_second_i) ? (item_first_i - item_second_i)
                                              : (item_second_i - item_first_i);
    sq      = SQ_W'(diff) * SQ_W'(diff);
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq);
    hit     = (item_second_i != '0) && (cnt_q < CNT_W'(MAX_ITEMS));
    sum_new = sum_q;
    cnt_new = cnt_q;
    if (hit) begin
      sum_new = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      cnt_new = cnt_q + CNT_W'(1);
    end
  end

  // Stall the stream only when the job queue is full
  assign item_ready_o = job_ready_i;
  assign accept       = item_valid_i && job_ready_i;
  assign job_valid_o  = item_valid_i && item_last_i;
  assign job_sum_o    = sum_new;
  assign job_cnt_o    = cnt_new;

  // Advance accumulators, clear after the last item
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (item_last_i) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/msa_queue.sv =====
module msa_queue #(
  parameter int unsigned WIDTH = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [WIDTH-1:0] pop_data_o
);
  import msa_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push, do_pop;

  assign not_full_o  = (fill_q != 2'd2);
  assign not_empty_o = (fill_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/msa_back.sv =====
module msa_back #(
  parameter int unsigned CNT_W = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msa_pkg::msa_cfg_t             cfg_i,
  input  logic                          job_valid_i,
  output logic                          job_pop_o,
  input  logic [msa_pkg::SUM_W-1:0]     job_sum_i,
  input  logic [CNT_W-1:0]              job_cnt_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [msa_pkg::SIM_W-1:0]     res_sim_o,
  output logic                          res_defined_o
);
  import msa_pkg::*;

  localparam int unsigned DIV_W  = (CNT_W > MINC_W) ? CNT_W : MINC_W;
  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam int unsigned PROD_W = PEN_W + MINC_W;

  msa_back_state_e  state_q, state_d;
  logic [SUM_W-1:0] job_sum_q, job_sum_d;
  logic [CNT_W-1:0] job_cnt_q, job_cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic             def_q, def_d;
  logic             out_valid_q, out_valid_d;
  logic [SIM_W-1:0] out_sim_q, out_sim_d;
  logic             out_def_q, out_def_d;

  logic             use_pen;
  logic [PROD_W-1:0] pen_prod;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             ge;
  logic [SUM_W-1:0] mag;

  // Shrinkage term and one restoring division step
  always_comb begin
    use_pen   = DIV_W'(job_cnt_q) < DIV_W'(cfg_i.min_common);
    pen_prod  = PROD_W'(cfg_i.missing_penalty) *
                PROD_W'(cfg_i.min_common - MINC_W'(job_cnt_q));
    trial     = {rem_q, num_q[NUM_W-1]};
    trial_sub = trial - {1'b0, div_q};
    ge        = trial >= {1'b0, div_q};
    mag       = num_q[NUM_W-1] ? SUM_MAX : num_q[SUM_W-1:0];
  end

  // Sequence: take job, set up division, iterate, hand off result
  always_comb begin
    state_d     = state_q;
    job_sum_d   = job_sum_q;
    job_cnt_d   = job_cnt_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    def_d       = def_q;
    out_valid_d = out_valid_q;
    out_sim_d   = out_sim_q;
    out_def_d   = out_def_q;
    job_pop_o   = 1'b0;

    // Drop the output request once taken
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_sum_d = job_sum_i;
          job_cnt_d = job_cnt_i;
          state_d   = B_PREP;
        end
      end
      B_PREP: begin
        def_d  = (job_cnt_q != '0);
        rem_d  = '0;
        step_d = '0;
        if (use_pen) begin
          num_d = {1'b0, job_sum_q} + NUM_W'(pen_prod);
          div_d = DIV_W'(cfg_i.min_common);
        end else begin
          num_d = {1'b0, job_sum_q};
          div_d = DIV_W'(job_cnt_q);
        end
        state_d = (job_cnt_q != '0) ? B_DIV : B_DONE;
      end
      B_DIV: begin
        num_d  = {num_q[NUM_W-2:0], ge};
        rem_d  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_def_d   = def_q;
          out_sim_d   = def_q ? (SIM_W'(0) - SIM_W'(mag)) : '0;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    job_sum_q <= job_sum_d;
    job_cnt_q <= job_cnt_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    step_q    <= step_d;
    def_q     <= def_d;
    out_sim_q <= out_sim_d;
    out_def_q <= out_def_d;
  end

  assign res_valid_o   = out_valid_q;
  assign res_sim_o     = out_sim_q;
  assign res_defined_o = out_def_q;

endmodule

// ===== sv/msd_similarity_accumulator.sv =====
// Takes one rating pair per cycle; the input stalls only while the 2-entry job queue is full.
// A result follows the last item of a list through the job queue, the job pop, setup,
// the bit-serial divider, and the output register load.
// The back end works on one list at a time; the front end keeps taking items meanwhile.
// Reset (rst_ni low, asynchronous) clears accumulators, queue and output valid,
// and sets min_common to 5 and missing_penalty to 1024.
module msd_similarity_accumulator #(
  parameter int unsigned MAX_ITEMS = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] rating_first, [15:8] rating_second
  input  logic [msa_pkg::TDATA_IN_W-1:0]       s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [28:0] similarity, [31:29] zero
  output logic [msa_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
  // [0] defined
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [msa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msa_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import msa_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned JOB_W = SUM_W + CNT_W;

  msa_cfg_t         cfg_q, cfg_d;
  logic             job_valid, job_ready, job_pop, q_not_empty;
  logic [SUM_W-1:0] front_sum;
  logic [CNT_W-1:0] front_cnt;
  logic [JOB_W-1:0] q_data;
  logic [SIM_W-1:0] res_sim;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_COMMON:      cfg_d.min_common      = cfg_data_i[MINC_W-1:0];
        CFG_MISSING_PENALTY: cfg_d.missing_penalty = cfg_data_i[PEN_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_common      <= MIN_COMMON_RST;
      cfg_q.missing_penalty <= PENALTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  msa_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_o  (s_axis_tready),
    .item_first_i  (s_axis_tdata[RATING_W-1:0]),
    .item_second_i (s_axis_tdata[2*RATING_W-1:RATING_W]),
    .item_last_i   (s_axis_tlast),
    .job_valid_o   (job_valid),
    .job_ready_i   (job_ready),
    .job_sum_o     (front_sum),
    .job_cnt_o     (front_cnt)
  );

  msa_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i ({front_cnt, front_sum}),
    .not_full_o  (job_ready),
    .pop_i       (job_pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (q_data)
  );

  msa_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_valid_i   (q_not_empty),
    .job_pop_o     (job_pop),
    .job_sum_i     (q_data[SUM_W-1:0]),
    .job_cnt_i     (q_data[JOB_W-1:SUM_W]),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_sim_o     (res_sim),
    .res_defined_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - SIM_W){1'b0}}, res_sim};

`ifndef SYNTH
  // An undefined result carries zero similarity
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("undefined result with nonzero similarity");

  // Similarity is never positive
  a_nonpositive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[SIM_W-1] || (m_axis_tdata[SIM_W-1:0] == '0)))
    else $error("positive similarity");

  // A popped job was present in the queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> q_not_empty)
    else $error("job popped from empty queue");
`endif

endmodule
